// ----- sv/utcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcd_pkg
// Constants, widths and the month-length table for the epoch-seconds
// calendar converter.
// ----------------------------------------------------------------------------
package utcd_pkg;

	localparam int unsigned SecsW  = 32;
	localparam int unsigned UnitW  = 35;
	localparam int unsigned CntW   = 4;
	localparam int unsigned YearW  = 12;

	localparam logic [16:0] SecsPerDay  = 17'd86400;
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [5:0]  SecsPerMin  = 6'd60;
	localparam logic [YearW-1:0] FirstYear = 12'd1970;

	// Residues of the first year, used to track the leap-year rule.
	localparam logic [1:0] FirstMod4   = 2'd2;
	localparam logic [6:0] FirstMod100 = 7'd70;
	localparam logic [8:0] FirstMod400 = 9'd370;

	localparam logic [3:0] LastMonthIdx = 4'd11;

	// Top quotient bit index for the three restoring divisions.
	localparam logic [CntW-1:0] DayTopBit  = 4'd15;
	localparam logic [CntW-1:0] HourTopBit = 4'd4;
	localparam logic [CntW-1:0] MinTopBit  = 4'd5;

	// Days in month m (0 = January), with February at 29 in a leap year.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd0:    d = 5'd31;
			4'd1:    d = leap ? 5'd29 : 5'd28;
			4'd2:    d = 5'd31;
			4'd3:    d = 5'd30;
			4'd4:    d = 5'd31;
			4'd5:    d = 5'd30;
			4'd6:    d = 5'd31;
			4'd7:    d = 5'd31;
			4'd8:    d = 5'd30;
			4'd9:    d = 5'd31;
			4'd10:   d = 5'd30;
			4'd11:   d = 5'd31;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- sv/utcd_sub_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utcd_sub_unit
// Shared compare-and-subtract unit: gives remainder minus operand and
// whether the remainder is at least the operand.
// ----------------------------------------------------------------------------
module utcd_sub_unit
	import utcd_pkg::*;
(
	input  wire logic [SecsW-1:0] rem,
	input  wire logic [UnitW-2:0] operand,
	output logic      [SecsW-1:0] diff,
	output logic                  ge
);

	logic [UnitW-1:0] full_diff;

	assign full_diff = {{(UnitW-SecsW){1'b0}}, rem} - {1'b0, operand};
	// A clear sign bit means no borrow, so the operand fits.
	assign ge   = ~full_diff[UnitW-1];
	assign diff = full_diff[SecsW-1:0];

endmodule
`default_nettype wire

// ----- sv/unix_time_to_calendar_date.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into Gregorian day, month, year, hour, minute and second.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// command   in         start, busy          epoch_seconds
// result    out        done (one cycle)     day_of_month, month_number,
//                                           year_number, hour_of_day,
//                                           minute_of_hour, second_of_minute
//
// A word is taken at a clock edge where start is high and busy is low; busy
// then stays high until the result word is shown. The length of a conversion
// grows with the number of years and months walked, and is set by the single
// compare-and-subtract unit, which serves every step of the conversion in turn.
// Reset clears the sequencer and the done strobe; the result ports keep
// their last word. The receiver cannot stall: done is high for exactly one
// cycle and the word must be taken then.
//
// How it works: the sequencer first runs a restoring division by 86400 (one
// quotient bit a cycle, 16 bits) to split off whole days, leaving the time of
// day in the remainder register. Two more short divisions by 3600 and 60 give
// the hour and minute, and the last remainder is the second. The day count is
// then moved into the remainder register and whole years are subtracted one
// per cycle, using 366 days for a leap year. Leap years are tracked with
// running residues modulo 4, 100 and 400, so no divider is needed. Finally
// whole months are subtracted, stopping at December at the latest.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_date
	import utcd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [SecsW-1:0] epoch_seconds,
	output logic                  done,
	output logic      [4:0]       day_of_month,
	output logic      [3:0]       month_number,
	output logic      [YearW-1:0] year_number,
	output logic      [4:0]       hour_of_day,
	output logic      [5:0]       minute_of_hour,
	output logic      [5:0]       second_of_minute
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StDay   = 3'd1;
	localparam logic [2:0] StHour  = 3'd2;
	localparam logic [2:0] StMin   = 3'd3;
	localparam logic [2:0] StYear  = 3'd4;
	localparam logic [2:0] StMonth = 3'd5;

	logic [2:0]       state_q;
	logic [CntW-1:0]  cnt_q;
	logic [SecsW-1:0] rem_q;
	logic [15:0]      quo_q;
	logic [15:0]      days_q;
	logic [4:0]       hour_q;
	logic [5:0]       min_q;
	logic [YearW-1:0] year_q;
	logic [1:0]       mod4_q;
	logic [6:0]       mod100_q;
	logic [8:0]       mod400_q;
	logic [3:0]       mon_q;

	logic             leap;
	logic [UnitW-2:0] operand;
	logic [SecsW-1:0] diff;
	logic             ge;
	logic [15:0]      quo_next;

	// Gregorian rule from the running residues of the current year.
	assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

	// Operand for the shared unit, chosen by the current step.
	always_comb begin
		case (state_q)
			StDay:   operand = {{(UnitW-1-17){1'b0}}, SecsPerDay} << cnt_q;
			StHour:  operand = {{(UnitW-1-12){1'b0}}, SecsPerHour} << cnt_q;
			StMin:   operand = {{(UnitW-1-6){1'b0}}, SecsPerMin} << cnt_q;
			StYear:  operand = leap ? (UnitW-1)'(366) : (UnitW-1)'(365);
			StMonth: operand = {{(UnitW-1-5){1'b0}}, month_days(mon_q, leap)};
			default: operand = '0;
		endcase
	end

	utcd_sub_unit u_sub (
		.rem     (rem_q),
		.operand (operand),
		.diff    (diff),
		.ge      (ge)
	);

	assign quo_next = {quo_q[14:0], ge};
	assign busy     = (state_q != StIdle);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				StIdle: begin
					if (start) begin
						state_q <= StDay;
					end
				end
				StDay: begin
					if (cnt_q == '0) begin
						state_q <= StHour;
					end
				end
				StHour: begin
					if (cnt_q == '0) begin
						state_q <= StMin;
					end
				end
				StMin: begin
					if (cnt_q == '0) begin
						state_q <= StYear;
					end
				end
				StYear: begin
					if (!ge) begin
						state_q <= StMonth;
					end
				end
				StMonth: begin
					if (!(ge && (mon_q < LastMonthIdx))) begin
						state_q <= StIdle;
						done    <= 1'b1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				rem_q    <= epoch_seconds;
				cnt_q    <= DayTopBit;
				quo_q    <= '0;
				year_q   <= FirstYear;
				mod4_q   <= FirstMod4;
				mod100_q <= FirstMod100;
				mod400_q <= FirstMod400;
				mon_q    <= '0;
			end
			StDay: begin
				if (ge) begin
					rem_q <= diff;
				end
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					days_q <= quo_next;
					cnt_q  <= HourTopBit;
				end
			end
			StHour: begin
				if (ge) begin
					rem_q <= diff;
				end
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					hour_q <= quo_next[4:0];
					cnt_q  <= MinTopBit;
				end
			end
			StMin: begin
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					min_q            <= quo_next[5:0];
					// The leftover seconds are final here; park them on the port.
					second_of_minute <= ge ? diff[5:0] : rem_q[5:0];
					rem_q            <= {{(SecsW-16){1'b0}}, days_q};
				end else if (ge) begin
					rem_q <= diff;
				end
			end
			StYear: begin
				if (ge) begin
					rem_q    <= diff;
					year_q   <= year_q + 12'd1;
					mod4_q   <= mod4_q + 2'd1;
					mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
				end
			end
			StMonth: begin
				if (ge && (mon_q < LastMonthIdx)) begin
					rem_q <= diff;
					mon_q <= mon_q + 4'd1;
				end else begin
					day_of_month   <= rem_q[4:0] + 5'd1;
					month_number   <= mon_q + 4'd1;
					year_number    <= year_q;
					hour_of_day    <= hour_q;
					minute_of_hour <= min_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule
`default_nettype wire
